// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared transaction types, status codes and map entry widths.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int CODE_W = 4;   // block order code, holds up to 15
    localparam int MOB_W  = 5;   // min_block_order register width
    localparam int ADDR_W = 24;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [1:0]        status;
    } t_out_item;

endpackage

// ===== design/bba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator
// Power-of-two buddy allocator over a pool of minimum-size slots.
// ----------------------------------------------------------------------------
// The allocator handles one transaction at a time. After reset it clears
// the slot map, holding o_in_stall high. An allocate first decodes the
// request. It then scans every slot of the map once through the single read
// port of the map RAM. After that it halves the found block until it has
// the requested size and marks the head used. A free decodes the address
// and checks the head. It then merges with its buddy while the buddy is a
// free block of equal size and the pool is not yet whole, and writes the
// new head. A refused request goes straight from its check to the result.
// A last step moves the result into the output register. A new transaction
// is taken while that result still waits, and the next result waits in turn
// until the receiver takes the first one.
module buddy_block_allocator #(
    parameter int SLOT_COUNT_LOG2 = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bba_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bba_pkg::t_out_item o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [4:0]        i_cfg_data
);
    import bba_pkg::*;

    localparam int L     = SLOT_COUNT_LOG2;
    localparam int SLOTS = 1 << L;
    localparam int DW    = CODE_W + 1;
    localparam logic [MOB_W-1:0] CAP = MOB_W'(24 - L);

    // One-hot sequencer states.
    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_DEC   = 11'b00000000100,
        S_SCAN  = 11'b00000001000,
        S_SPLIT = 11'b00000010000,
        S_AFIN  = 11'b00000100000,
        S_FCHK  = 11'b00001000000,
        S_MRD   = 11'b00010000000,
        S_MCHK  = 11'b00100000000,
        S_FFIN  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [MOB_W-1:0]  r_mob;
    t_in_item          r_item;
    logic [L:0]        r_idx, n_idx;
    logic              r_svld, n_svld;
    logic [L-1:0]      r_prev, n_prev;
    logic              r_found, n_found;
    logic [L-1:0]      r_pos, n_pos;
    logic [CODE_W-1:0] r_ord, n_ord;
    logic [CODE_W-1:0] r_need, n_need;
    t_status           r_st, n_st;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic              r_oval, n_oval;
    t_out_item         r_out, n_out;

    // RAM port signals.
    logic          we;
    logic [L-1:0]  waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic          rd_used;
    logic [CODE_W-1:0] rd_code;

    bba_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_map (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rd_used = rdata[DW-1];
    assign rd_code = rdata[CODE_W-1:0];

    // Effective slot order: the smallest of the register, 16 and 24 - L.
    logic [MOB_W-1:0] m;
    always_comb begin
        m = r_mob;
        if (m > MOB_W'(16)) m = MOB_W'(16);
        if (m > CAP) m = CAP;
    end

    // Rounded-up order of the request, zero counting as one.
    logic [ADDR_W-1:0] req_m1;
    logic [MOB_W-1:0]  kb;
    always_comb begin
        req_m1 = (r_item.request_bytes == '0) ? '0 : r_item.request_bytes - 1'b1;
        kb = '0;
        for (int b = 0; b < ADDR_W; b++) begin
            if (req_m1[b]) kb = MOB_W'(b + 1);
        end
    end

    logic [MOB_W-1:0]  need_full;
    assign need_full = (kb > m) ? kb - m : '0;

    // Free address decode.
    logic [ADDR_W-1:0] f_low_mask, f_pos_full;
    logic              f_bad_addr;
    always_comb begin
        f_low_mask = ~(({ADDR_W{1'b1}}) << m);
        f_pos_full = r_item.block_address >> m;
        f_bad_addr = ((r_item.block_address & f_low_mask) != '0) ||
                     ((f_pos_full >> L) != '0);
    end

    logic [L-1:0] one_l;
    assign one_l = {{(L-1){1'b0}}, 1'b1};

    logic [L-1:0] bit_ord, bit_ordm1, buddy;
    assign bit_ord   = one_l << r_ord;
    assign bit_ordm1 = one_l << (r_ord - 1'b1);
    assign buddy     = r_pos ^ bit_ord;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_svld     = 1'b0;
        n_prev     = r_prev;
        n_found    = r_found;
        n_pos      = r_pos;
        n_ord      = r_ord;
        n_need     = r_need;
        n_st       = r_st;
        n_res_addr = r_res_addr;
        n_oval     = r_oval;
        n_out      = r_out;
        we         = 1'b0;
        waddr      = r_pos;
        wdata      = '0;
        raddr      = r_pos;

        if (r_oval && !i_out_stall) n_oval = 1'b0;

        case (r_state)
            S_CLR: begin
                // Clearing pass: slot 0 holds the whole pool.
                we    = 1'b1;
                waddr = r_idx[L-1:0];
                wdata = (r_idx == '0) ? {1'b0, CODE_W'(L + 1)} : '0;
                n_idx = r_idx + 1'b1;
                if (r_idx[L-1:0] == {L{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                n_res_addr = '0;
                if (r_item.action == ACT_ALLOC) begin
                    n_need  = CODE_W'(need_full);
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (need_full > MOB_W'(L)) begin
                        n_st    = ST_OOM;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (f_bad_addr) begin
                    n_st    = ST_BADFREE;
                    n_state = S_DONE;
                end else begin
                    n_pos   = f_pos_full[L-1:0];
                    raddr   = f_pos_full[L-1:0];
                    n_state = S_FCHK;
                end
            end
            S_SCAN: begin
                // Read one slot a cycle, judge the slot read the cycle before.
                // A free head wins when its order is strictly smaller than the
                // best one so far, so the lowest slot wins among equal sizes.
                if (r_svld && !rd_used && rd_code > r_need &&
                    (!r_found || rd_code <= r_ord)) begin
                    n_found = 1'b1;
                    n_pos   = r_prev;
                    n_ord   = rd_code - 1'b1;
                end
                if (!r_svld) n_ord = r_found ? r_ord : '1;
                if (r_idx < (L+1)'(SLOTS)) begin
                    raddr  = r_idx[L-1:0];
                    n_prev = r_idx[L-1:0];
                    n_svld = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end else if (!r_svld) begin
                    if (r_found) begin
                        n_state = S_SPLIT;
                    end else begin
                        n_st    = ST_OOM;
                        n_state = S_DONE;
                    end
                end
            end
            S_SPLIT: begin
                if (r_ord > r_need) begin
                    we    = 1'b1;
                    waddr = r_pos | bit_ordm1;
                    wdata = {1'b0, r_ord};
                    n_ord = r_ord - 1'b1;
                end else begin
                    n_state = S_AFIN;
                end
            end
            S_AFIN: begin
                we         = 1'b1;
                waddr      = r_pos;
                wdata      = {1'b1, r_need + 1'b1};
                n_res_addr = ADDR_W'(r_pos) << m;
                n_st       = ST_OK;
                n_state    = S_DONE;
            end
            S_FCHK: begin
                if (rd_code == '0 || !rd_used) begin
                    n_st    = ST_BADFREE;
                    n_state = S_DONE;
                end else begin
                    n_ord   = rd_code - 1'b1;
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                if (r_ord < CODE_W'(L)) begin
                    raddr   = buddy;
                    n_state = S_MCHK;
                end else begin
                    n_state = S_FFIN;
                end
            end
            S_MCHK: begin
                if (rd_used || rd_code != r_ord + 1'b1) begin
                    n_state = S_FFIN;
                end else begin
                    we      = 1'b1;
                    waddr   = r_pos | bit_ord;
                    wdata   = '0;
                    n_pos   = r_pos & ~bit_ord;
                    n_ord   = r_ord + 1'b1;
                    n_state = S_MRD;
                end
            end
            S_FFIN: begin
                we      = 1'b1;
                waddr   = r_pos;
                wdata   = {1'b0, r_ord + 1'b1};
                n_st    = ST_OK;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_oval || !i_out_stall) begin
                    n_oval         = 1'b1;
                    n_out.address  = r_res_addr;
                    n_out.status   = r_st;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_svld  <= 1'b0;
            r_found <= 1'b0;
            r_oval  <= 1'b0;
            r_mob   <= MOB_W'(4);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_svld  <= n_svld;
            r_found <= n_found;
            r_oval  <= n_oval;
            if (i_cfg_valid) r_mob <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_item <= i_in_item;
        r_prev     <= n_prev;
        r_pos      <= n_pos;
        r_ord      <= n_ord;
        r_need     <= n_need;
        r_st       <= n_st;
        r_res_addr <= n_res_addr;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_oval;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;
endmodule

// ===== design/bba_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input bba_pkg::t_out_item o_out_item
);
    import bba_pkg::*;

    // An accepted transaction keeps the input stalled in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transaction");

    // Only defined status codes leave the block.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == ST_OK ||
                         o_out_item.status == ST_OOM ||
                         o_out_item.status == ST_BADFREE))
        else $error("undefined status");

    // A failed transaction carries a zero offset.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK) |-> (o_out_item.address == '0))
        else $error("nonzero offset on failure");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

// ===== test/bba_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Watches the input, output and register channels of the allocator, keeps
// its own copy of the slot maps and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bba_scoreboard
    import bba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [4:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int POOL_LOG2 = 8;
    localparam int POOL_SLOTS = 1 << POOL_LOG2;

    logic [CODE_W-1:0] order_map [POOL_SLOTS];
    logic              used_map  [POOL_SLOTS];
    logic [MOB_W-1:0]  slot_order_reg;
    t_out_item         awaited_results [$];

    function automatic int slot_order();
        int m;
        m = slot_order_reg;
        if (m > 16) m = 16;
        if (m > 24 - POOL_LOG2) m = 24 - POOL_LOG2;
        return m;
    endfunction

    function automatic t_out_item grant_block(logic [ADDR_W-1:0] req);
        t_out_item res;
        int m, n, kb, need, pos, ord;
        bit found;
        m = slot_order();
        n = (req == 0) ? 1 : int'(req);
        kb = 0;
        found = 0;
        pos = 0;
        ord = 0;
        res.address = '0;
        res.status = ST_OOM;
        while (kb < 31 && (1 << kb) < n) kb++;
        need = (kb > m) ? kb - m : 0;
        if (need > POOL_LOG2) return res;
        for (int j = need; j <= POOL_LOG2 && !found; j++) begin
            for (int i = 0; i < POOL_SLOTS && !found; i++) begin
                if (!used_map[i] && order_map[i] == j + 1) begin
                    pos = i;
                    ord = j;
                    found = 1;
                end
            end
        end
        if (!found) return res;
        // Halve the block until it is the requested size.
        while (ord > need) begin
            ord--;
            order_map[pos] = CODE_W'(ord + 1);
            order_map[(pos + (1 << ord)) & (POOL_SLOTS - 1)] = CODE_W'(ord + 1);
        end
        used_map[pos] = 1'b1;
        res.address = ADDR_W'(pos << m);
        res.status = ST_OK;
        return res;
    endfunction

    function automatic t_out_item release_block(logic [ADDR_W-1:0] addr);
        t_out_item res;
        int m, pos, ord, buddy, lo, hi;
        m = slot_order();
        pos = int'(addr) >> m;
        res.address = '0;
        res.status = ST_BADFREE;
        if ((int'(addr) & ((1 << m) - 1)) != 0) return res;
        if (pos >= POOL_SLOTS) return res;
        if (order_map[pos] == 0 || !used_map[pos]) return res;
        used_map[pos] = 1'b0;
        ord = order_map[pos] - 1;
        // Merge upward while the aligned buddy is a free block of equal size.
        while (ord < POOL_LOG2) begin
            buddy = pos ^ (1 << ord);
            if (used_map[buddy] || order_map[buddy] != ord + 1) break;
            lo = (pos < buddy) ? pos : buddy;
            hi = (pos < buddy) ? buddy : pos;
            order_map[hi] = '0;
            ord++;
            order_map[lo] = CODE_W'(ord + 1);
            pos = lo;
        end
        res.status = ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
                order_map[i] = '0;
                used_map[i] = 1'b0;
            end
            order_map[0] = CODE_W'(POOL_LOG2 + 1);
            slot_order_reg = MOB_W'(4);
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) slot_order_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.action == ACT_FREE)
                    awaited_results.push_back(release_block(i_in_item.block_address));
                else
                    awaited_results.push_back(grant_block(i_in_item.request_bytes));
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.address !== want.address)
                        report_mismatch($sformatf("address got %h want %h",
                            i_out_item.address, want.address));
                    if (i_out_item.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            i_out_item.status, want.status));
                end
            end
        end
        o_pending = awaited_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives directed and random allocate and free transactions through several
// slot sizes, with random stalls on both sides, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import bba_pkg::*;

    localparam int IDLE_LIMIT = 20000;   // cycles without any transaction
    localparam int HOLD_CYCLES = 2000;   // long receiver hold-off
    localparam int PHASE_ITEMS = 230;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;
    int         fail_count;
    int         pending;

    // Stimulus bookkeeping: the slot index of every block the random part
    // still holds, and the action of every transaction awaiting its result.
    int         held_slots [$];
    t_action    sent_actions [$];
    bit         track_held;
    int         cur_order;
    bit         quiet;
    bit         hold_req;
    int         idle_cycles;

    buddy_block_allocator #(.SLOT_COUNT_LOG2(8)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    bba_scoreboard chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offers one transaction, starting at a falling edge, and returns at the
    // falling edge after it was taken. Valid only drops for a random gap, so
    // back-to-back transactions keep it high.
    task automatic offer_item(input t_in_item it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (in_stall);
        sent_actions.push_back(t_action'(it.action));
        @(negedge i_clk);
    endtask

    task automatic send_alloc(input int unsigned req);
        t_in_item it;
        it.action = ACT_ALLOC;
        it.request_bytes = (req > 24'hFFFFFF) ? 24'hFFFFFF : ADDR_W'(req);
        it.block_address = ADDR_W'($urandom());
        offer_item(it);
    endtask

    task automatic send_free(input int unsigned addr);
        t_in_item it;
        it.action = ACT_FREE;
        it.request_bytes = ADDR_W'($urandom());
        it.block_address = ADDR_W'(addr);
        offer_item(it);
    endtask

    // Register writes happen only with the allocator drained.
    task automatic set_slot_order(input int value);
        cfg_valid <= 1'b1;
        cfg_data <= 5'(value);
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        cur_order = (value > 16) ? 16 : value;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // One random transaction. Most frees return blocks that are still held;
    // a share are stray addresses, refused unless one is a held block's head.
    task automatic random_item();
        int r, k, pick;
        int unsigned req;
        r = $urandom_range(0, 99);
        if (held_slots.size() > 0 && (r < 35 || (held_slots.size() > 48 && r < 70))) begin
            pick = $urandom_range(0, held_slots.size() - 1);
            send_free(held_slots[pick] << cur_order);
            held_slots.delete(pick);
        end else if (r < 45) begin
            if ($urandom_range(0, 1) == 0)
                send_free($urandom_range(0, 24'hFFFFFF));
            else
                send_free($urandom_range(0, 255) << cur_order);
        end else begin
            k = $urandom_range(0, 19);
            if (k == 0)
                req = $urandom_range(0, 24'hFFFFFF);
            else if (k == 1)
                req = $urandom_range(0, 256 << cur_order);
            else
                req = $urandom_range(0, 1 << (cur_order + $urandom_range(0, 5)));
            send_alloc(req);
        end
    endtask

    // Result side bookkeeping: learn which blocks the random part now holds.
    always @(posedge i_clk) begin
        t_action act;
        if (i_rst_n && out_valid && !out_stall && sent_actions.size() > 0) begin
            act = sent_actions.pop_front();
            if (track_held && act == ACT_ALLOC && out_item.status == ST_OK)
                held_slots.push_back(int'(out_item.address) >> cur_order);
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, and no
    // stalls at all once the quiet tail starts.
    initial begin
        bit held_once;
        held_once = 0;
        out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req && !held_once) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held_once = 1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    end

    // Watchdog on cycles in which no channel completes a transaction.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** buddy_block_allocator: FAILED **");
            $finish;
        end
    end

    initial begin
        int orders [6];
        orders = '{4, 0, 16, 31, 9, 4};
        idle_cycles = 0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 0;
        hold_req = 0;
        track_held = 0;
        cur_order = 4;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with 16-byte slots: a 4 KiB pool.
        set_slot_order(4);
        send_alloc(0);                 // zero counts as one byte
        send_alloc(1);
        send_alloc(4096);              // whole pool no longer free
        send_alloc(24'hFFFFFF);        // larger than the pool
        send_alloc(17);                // rounds up to 32 bytes
        send_free(8);                  // not slot aligned
        send_free(24'h800000);         // beyond the pool
        send_free(48);                 // not the head of a held block
        send_free(0);
        send_free(0);                  // double free
        send_free(16);                 // merges with its buddy
        send_free(32);                 // pool is whole again
        send_alloc(4096);
        send_alloc(1);                 // nothing left
        send_free(0);
        send_alloc(2048);
        send_alloc(2000);
        send_alloc(1);
        send_free(2048);
        send_free(0);
        wait_drained();

        track_held = 1;
        held_slots.delete();
        for (int p = 0; p < 6; p++) begin
            if (p > 0) set_slot_order(orders[p]);
            if (p == 1) hold_req = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == PHASE_ITEMS / 2) quiet = 1;
                random_item();
            end
            wait_drained();
        end

        repeat (300) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** buddy_block_allocator: PASSED **");
        else
            $display("** buddy_block_allocator: FAILED **");
        $finish;
    end

endmodule
